/* hdl/dtq_pkg.sv */
package dtq_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIRE   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_DROP  = 2'd1,
    FSM_INS   = 2'd2,
    FSM_DONE  = 2'd3
  } fsm_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] delta;
    logic [7:0]  cb;
    logic [31:0] data;
    logic [31:0] total;     // expiry counted from now, running sum of deltas
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        drop;      // cells at or below drop point pull from tail-side neighbor
    logic        ins;       // insert step
    logic        fire;      // pop head
    logic [7:0]  id;
    logic [31:0] delay;
    logic [7:0]  cb;
    logic [31:0] data;
  } cell_cmd_t;

endpackage

/* hdl/dtq_cell.sv */
// One queue slot. Besides its delta each slot keeps its expiry counted from
// now, so every cell finds the insert point with a compare of its own;
// a remove/insert is settled in one step.
module dtq_cell (
  input  logic                clk_i,
  input  dtq_pkg::cell_cmd_t  cmd_i,
  input  logic                valid_i,
  input  logic                prev_valid_i,
  input  dtq_pkg::entry_t     prev_i,
  input  logic [31:0]         prev_total_i,
  input  dtq_pkg::entry_t     next_i,
  input  logic [31:0]         head_total_i,
  // drop chain
  input  logic                hit_above_i,
  output logic                hit_below_o,
  // insert point
  input  logic                pos_above_i,
  output logic                pos_below_o,
  output dtq_pkg::entry_t     entry_o
);
  import dtq_pkg::*;

  entry_t ent_q, ent_d;
  logic   hit_here, at_pos, past_pos;

  assign hit_here    = valid_i && (ent_q.id == cmd_i.id);
  assign hit_below_o = hit_above_i || hit_here;

  // totals rise along the valid slots, so this flag is a thermometer
  assign past_pos    = !valid_i || (ent_q.total > cmd_i.delay);
  assign pos_below_o = past_pos;
  assign at_pos      = past_pos && !pos_above_i;
  assign entry_o     = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.drop) begin
      if (hit_here) begin
        ent_d = next_i;
        ent_d.delta = next_i.delta + ent_q.delta;
      end else if (hit_above_i) begin
        ent_d = next_i;
      end
    end else if (cmd_i.fire) begin
      ent_d = next_i;
      ent_d.total = next_i.total - head_total_i;
    end else if (cmd_i.ins) begin
      if (at_pos) begin
        ent_d.id    = cmd_i.id;
        ent_d.delta = cmd_i.delay - prev_total_i;
        ent_d.cb    = cmd_i.cb;
        ent_d.data  = cmd_i.data;
        ent_d.total = cmd_i.delay;
      end else if (pos_above_i && prev_valid_i) begin
        ent_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

/* hdl/dtq_chain.sv */
module dtq_chain #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  dtq_pkg::cell_cmd_t           cmd_i,
  input  logic [QUEUE_DEPTH-1:0]       valid_i,
  output logic                         hit_o,
  output dtq_pkg::entry_t              head_o
);
  import dtq_pkg::*;

  entry_t               ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] hit_c, pos_c;

  assign hit_c[0] = 1'b0;
  assign pos_c[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      entry_t      prev_s, next_s;
      logic        prev_v;
      logic [31:0] prev_tot;
      if (g == 0) begin : g_p0
        assign prev_s   = '0;
        assign prev_v   = 1'b0;
        assign prev_tot = '0;
      end else begin : g_pn
        // when the new entry lands just above, the successor keeps its expiry
        always_comb begin
          prev_s = ent[g-1];
          if (pos_c[g] && !pos_c[g-1]) begin
            prev_s.delta = ent[g-1].total - cmd_i.delay;
          end
        end
        assign prev_v   = valid_i[g-1];
        assign prev_tot = ent[g-1].total;
      end
      if (g == QUEUE_DEPTH-1) begin : g_nl
        assign next_s = '0;
      end else begin : g_nn
        assign next_s = ent[g+1];
      end
      dtq_cell u_cell (
        .clk_i       (clk_i),
        .cmd_i       (cmd_i),
        .valid_i     (valid_i[g]),
        .prev_valid_i(prev_v),
        .prev_i      (prev_s),
        .prev_total_i(prev_tot),
        .next_i      (next_s),
        .head_total_i(ent[0].total),
        .hit_above_i (hit_c[g]),
        .hit_below_o (hit_c[g+1]),
        .pos_above_i (pos_c[g]),
        .pos_below_o (pos_c[g+1]),
        .entry_o     (ent[g])
      );
    end
  endgenerate

  assign hit_o  = hit_c[QUEUE_DEPTH];
  assign head_o = ent[0];

endmodule

/* hdl/delta_timer_queue_top.sv */
// An add steps through the states id drop, insert and finish; a remove
// through id drop and finish; fire and the idle opcode through finish alone.
// Busy is high in each of these states; done_o is registered out of finish.
// One command in flight; busy drops in the strobe cycle, so the next start
// can be taken there. The receiver cannot stall.
// Reset (rst_ni low, async) empties the queue; slot contents stay undefined.
module delta_timer_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           timer_id_i,
  input  logic [31:0]          delay_us_i,
  input  logic [7:0]           callback_id_i,
  input  logic [31:0]          data_tag_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [7:0]           fired_id_o,
  output logic [7:0]           fired_callback_o,
  output logic [31:0]          fired_data_o
);
  import dtq_pkg::*;

  fsm_e  st_q, st_d;
  logic [QUEUE_DEPTH-1:0] vld_q, vld_d;
  op_e   op_q;
  logic [7:0]  id_q, cb_q;
  logic [31:0] dly_q, dat_q;
  logic [1:0]  sts_q, sts_d;
  entry_t      fo_q, fo_d;
  logic        done_q, done_d;
  cell_cmd_t   cmd;
  logic        hit;
  entry_t      head;
  logic        accept;

  assign accept = start && !busy;
  assign busy   = (st_q != FSM_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.id    = id_q;
    cmd.delay = dly_q;
    cmd.cb    = cb_q;
    cmd.data  = dat_q;
    cmd.drop  = (st_q == FSM_DROP);
    cmd.ins   = (st_q == FSM_INS) && !vld_q[QUEUE_DEPTH-1];
    cmd.fire  = (st_q == FSM_DONE) && (op_q == OP_FIRE) && vld_q[0];
  end

  dtq_chain #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chain (
    .clk_i (clk_i),
    .cmd_i (cmd),
    .valid_i(vld_q),
    .hit_o (hit),
    .head_o(head)
  );

  always_comb begin
    st_d   = st_q;
    vld_d  = vld_q;
    sts_d  = sts_q;
    fo_d   = '0;
    done_d = 1'b0;
    case (st_q)
      FSM_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_ADD, OP_REMOVE: st_d = FSM_DROP;
            default:           st_d = FSM_DONE;
          endcase
          sts_d = ST_OK;
        end
      end
      FSM_DROP: begin
        if (hit) begin
          vld_d = vld_q >> 1;
        end
        if (op_q == OP_ADD) begin
          st_d = FSM_INS;
        end else begin
          if (!hit) sts_d = ST_NOT_FOUND;
          st_d = FSM_DONE;
        end
      end
      FSM_INS: begin
        if (vld_q[QUEUE_DEPTH-1]) begin
          sts_d = ST_FULL;
        end else begin
          vld_d = {vld_q[QUEUE_DEPTH-2:0], 1'b1};
        end
        st_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (op_q == OP_FIRE) begin
          if (vld_q[0]) begin
            fo_d  = head;
            vld_d = vld_q >> 1;
          end else begin
            sts_d = ST_EMPTY;
          end
        end
        done_d = 1'b1;
        st_d   = FSM_IDLE;
      end
      default: st_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= FSM_IDLE;
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      vld_q  <= vld_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      id_q  <= timer_id_i;
      dly_q <= delay_us_i;
      cb_q  <= callback_id_i;
      dat_q <= data_tag_i;
    end
    sts_q <= sts_d;
    if (st_q == FSM_DONE) fo_q <= fo_d;
  end

  assign done_o           = done_q;
  assign status_o         = done_q ? sts_q : ST_OK;
  assign fired_id_o       = done_q ? fo_q.id : 8'd0;
  assign fired_callback_o = done_q ? fo_q.cb : 8'd0;
  assign fired_data_o     = done_q ? fo_q.data : 32'd0;

endmodule

/* hdl/dtq_checker.sv */
module dtq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] status_o,
  input logic [7:0] fired_id_o
);
  import dtq_pkg::*;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("no busy after start");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy with result");
  a_fire_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> fired_id_o == 8'd0) else $error("stray id");
endmodule

bind delta_timer_queue_top dtq_checker u_dtq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .status_o(status_o), .fired_id_o(fired_id_o)
);
